// File: rtl/core/sfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants for the sniffer frame deframer.
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam logic [7:0] SFD_SOF1     = 8'h40;
  localparam logic [7:0] SFD_SOF2     = 8'h53;
  localparam logic [7:0] SFD_TYPE_ADJ = 8'hC0;
  localparam logic [7:0] SFD_CHK_BAD  = 8'h00;
  localparam logic [7:0] SFD_EOF1     = 8'h40;
  localparam logic [7:0] SFD_EOF2     = 8'h45;

  typedef enum logic [3:0] {
    PH_START1  = 4'd0,
    PH_START2  = 4'd1,
    PH_TYPE    = 4'd2,
    PH_LENLO   = 4'd3,
    PH_LENHI   = 4'd4,
    PH_PAYLOAD = 4'd5,
    PH_CHECK   = 4'd6,
    PH_END1    = 4'd7,
    PH_END2    = 4'd8,
    PH_ERROR   = 4'd9,
    PH_SUCCESS = 4'd10
  } sfd_phase_t;

  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
  } sfd_in_t;

  typedef struct packed {
    logic [3:0]  phase_code;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [7:0]  frame_type_out;
    logic [15:0] frame_length_out;
    logic [7:0]  check_byte_out;
    logic        frame_ok;
  } sfd_out_t;

  typedef struct packed {
    sfd_phase_t  phase;
    logic [7:0]  type_byte;
    logic [15:0] length;
    logic [15:0] index;
    logic [7:0]  check;
    logic        ok;
  } sfd_state_t;

  localparam sfd_state_t SFD_ST_CLEAR = '{PH_START1, 8'd0, 16'd0, 16'd0, 8'd0, 1'b0};

endpackage

// File: rtl/core/sfd_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_step
// Next-state and result logic of the frame parser for one byte.
// ----------------------------------------------------------------------------
module sfd_step (
  input  sfd_pkg::sfd_state_t st,
  input  sfd_pkg::sfd_in_t    item,
  output sfd_pkg::sfd_state_t st_nxt,
  output sfd_pkg::sfd_out_t   result
);
  import sfd_pkg::*;

  sfd_state_t  base;
  sfd_state_t  nxt;
  logic        pv;
  logic [7:0]  pb;
  logic [15:0] pi;
  logic [15:0] len_full;
  logic [15:0] len_adj;
  logic [16:0] idx_inc;

  assign len_full = {item.data_byte, base.length[7:0]};
  assign len_adj  = (base.type_byte == SFD_TYPE_ADJ) ? len_full - 16'd1 : len_full;
  assign idx_inc  = {1'b0, base.index} + 17'd1;

  always_comb begin
    // a byte after success starts a fresh frame
    base = (st.phase == PH_SUCCESS) ? SFD_ST_CLEAR : st;
    nxt  = base;
    pv   = 1'b0;
    pb   = 8'd0;
    pi   = 16'd0;
    if (item.func) begin
      nxt = SFD_ST_CLEAR;
    end else if (st.phase == PH_ERROR) begin
      nxt = st;
    end else begin
      unique case (base.phase)
        PH_START2: begin
          nxt.phase = (item.data_byte == SFD_SOF2) ? PH_TYPE : PH_ERROR;
        end
        PH_TYPE: begin
          nxt.type_byte = item.data_byte;
          nxt.phase     = PH_LENLO;
        end
        PH_LENLO: begin
          nxt.length = {8'd0, item.data_byte};
          nxt.phase  = PH_LENHI;
        end
        PH_LENHI: begin
          nxt.length = len_adj;
          nxt.index  = 16'd0;
          nxt.phase  = (len_adj == 16'd0) ? PH_CHECK : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          pv = 1'b1;
          pb = item.data_byte;
          pi = base.index;
          if (base.length == 16'd0 || idx_inc >= {1'b0, base.length}) begin
            nxt.phase = PH_CHECK;
          end
          nxt.index = idx_inc[15:0];
        end
        PH_CHECK: begin
          nxt.check = item.data_byte;
          nxt.phase = (item.data_byte != SFD_CHK_BAD) ? PH_END1 : PH_ERROR;
        end
        PH_END1: begin
          nxt.phase = (item.data_byte == SFD_EOF1) ? PH_END2 : PH_ERROR;
        end
        PH_END2: begin
          if (item.data_byte == SFD_EOF2) begin
            nxt.phase = PH_SUCCESS;
            nxt.ok    = 1'b1;
          end else begin
            nxt.phase = PH_ERROR;
          end
        end
        default: begin
          nxt.phase = (item.data_byte == SFD_SOF1) ? PH_START2 : PH_ERROR;
        end
      endcase
    end
  end

  assign st_nxt = nxt;

  always_comb begin
    result.phase_code       = nxt.phase;
    result.payload_valid    = pv;
    result.payload_byte     = pb;
    result.payload_index    = pi;
    result.frame_type_out   = nxt.type_byte;
    result.frame_length_out = nxt.length;
    result.check_byte_out   = nxt.check;
    result.frame_ok         = nxt.ok;
  end

endmodule

// File: rtl/core/sniffer_frame_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sniffer_frame_deframer
// Byte-stream frame parser: SOF 40 53, type, LE length, payload, check, EOF 40 45.
//
// Usage:
//   in_data carries one byte (or a recover request) per transaction; every
//   transaction yields exactly one transaction on out_data with the parser
//   phase after that byte, the payload byte and its index when it was one,
//   and the frame type, length, check byte and frame-ok flag seen so far.
//   From input accept, the byte sits in the input register and the result
//   register loads from it once the output side is free.
//   Throughput is one byte per cycle while out_stall is low, set by the single
//   parser state update between the two registers.
//   A bad byte parks the parser in the error phase until a recover item.
//   Reset (rst_n low, synchronous) empties both registers and returns the
//   parser to start1 with all frame fields zero.
//   When out_stall holds a result, one more byte is taken into the input
//   register; in_stall rises only when both registers are full.
// ----------------------------------------------------------------------------
module sniffer_frame_deframer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sfd_pkg::sfd_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output sfd_pkg::sfd_out_t out_data
);
  import sfd_pkg::*;

  logic       in_valid_r;
  sfd_in_t    in_data_r;
  logic       out_valid_r;
  sfd_out_t   out_data_r;
  sfd_state_t st_r;
  sfd_state_t st_nxt;
  sfd_out_t   result;
  logic       out_free;
  logic       fire;

  assign out_free = !out_valid_r || !out_stall;
  assign fire     = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;

  sfd_step u_step (
    .st     (st_r),
    .item   (in_data_r),
    .st_nxt (st_nxt),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= SFD_ST_CLEAR;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (out_free) begin
        out_valid_r <= in_valid_r;
      end
      if (fire) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_data_r <= in_data;
    end
    if (fire) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/core/sfd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_checker
// Port-level checks for the sniffer frame deframer, bound to the top level.
// ----------------------------------------------------------------------------
module sfd_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input sfd_pkg::sfd_out_t out_data
);
  import sfd_pkg::*;

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // non-payload results carry zero byte and index
  a_no_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.payload_valid |->
      out_data.payload_byte == 8'd0 && out_data.payload_index == 16'd0)
    else $error("payload fields set without payload_valid");

  // a payload byte leaves the parser in payload or check
  a_payload_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.payload_valid |->
      out_data.phase_code == PH_PAYLOAD || out_data.phase_code == PH_CHECK)
    else $error("payload byte outside payload phase");

  // frame_ok is only visible in the success phase
  a_ok_success: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_ok |-> out_data.phase_code == PH_SUCCESS)
    else $error("frame_ok outside success");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind sniffer_frame_deframer sfd_checker u_sfd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: verif/tb_sniffer_frame_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sniffer_frame_deframer
// Drives byte transactions (data and recover) into the deframer. A scoreboard
// predicts every result from its own copy of the parser state and checks each
// result transaction field by field, in order. Random idle gaps are applied on
// both channels, with some stretches at full rate.
// ----------------------------------------------------------------------------
module tb_sniffer_frame_deframer;
  import sfd_pkg::*;

  class sfd_scoreboard;
    logic [3:0]  phase_now;
    logic [7:0]  type_now;
    logic [15:0] length_now;
    logic [15:0] index_now;
    logic [7:0]  check_now;
    logic        ok_now;
    sfd_out_t    expected_results[$];
    int          errors;

    function new();
      clear_frame();
      errors = 0;
    endfunction

    function void clear_frame();
      phase_now  = PH_START1;
      type_now   = 8'd0;
      length_now = 16'd0;
      index_now  = 16'd0;
      check_now  = 8'd0;
      ok_now     = 1'b0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Advance the parser by one accepted transaction and queue its result.
    function void note_input(sfd_in_t item);
      sfd_out_t   res;
      logic [7:0] b;
      b = item.data_byte;
      res = '0;
      if (item.func) begin
        clear_frame();
      end else if (phase_now != PH_ERROR) begin
        // a finished frame is dropped and this byte starts the next one
        if (phase_now == PH_SUCCESS) clear_frame();
        case (phase_now)
          PH_START2: phase_now = (b == SFD_SOF2) ? PH_TYPE : PH_ERROR;
          PH_TYPE: begin
            type_now  = b;
            phase_now = PH_LENLO;
          end
          PH_LENLO: begin
            length_now = {8'h00, b};
            phase_now  = PH_LENHI;
          end
          PH_LENHI: begin
            length_now = {b, length_now[7:0]};
            if (type_now == SFD_TYPE_ADJ) length_now = length_now - 16'd1;
            index_now = 16'd0;
            phase_now = (length_now == 16'd0) ? PH_CHECK : PH_PAYLOAD;
          end
          PH_PAYLOAD: begin
            res.payload_valid = 1'b1;
            res.payload_byte  = b;
            res.payload_index = index_now;
            if (length_now == 16'd0 || {1'b0, index_now} + 17'd1 >= {1'b0, length_now})
              phase_now = PH_CHECK;
            index_now = index_now + 16'd1;
          end
          PH_CHECK: begin
            check_now = b;
            phase_now = (b != SFD_CHK_BAD) ? PH_END1 : PH_ERROR;
          end
          PH_END1: phase_now = (b == SFD_EOF1) ? PH_END2 : PH_ERROR;
          PH_END2: begin
            if (b == SFD_EOF2) begin
              phase_now = PH_SUCCESS;
              ok_now    = 1'b1;
            end else begin
              phase_now = PH_ERROR;
            end
          end
          default: phase_now = (b == SFD_SOF1) ? PH_START2 : PH_ERROR;
        endcase
      end
      res.phase_code       = phase_now;
      res.frame_type_out   = type_now;
      res.frame_length_out = length_now;
      res.check_byte_out   = check_now;
      res.frame_ok         = ok_now;
      expected_results.push_back(res);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      if (errors < 40)
        $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
      errors++;
    endtask

    task check_result(sfd_out_t got);
      sfd_out_t want;
      if (expected_results.size() == 0) begin
        report("result with nothing expected", 32'(got.phase_code), 32'd0);
        return;
      end
      want = expected_results.pop_front();
      if (got.phase_code !== want.phase_code)
        report("phase_code", 32'(got.phase_code), 32'(want.phase_code));
      if (got.payload_valid !== want.payload_valid)
        report("payload_valid", 32'(got.payload_valid), 32'(want.payload_valid));
      if (got.payload_byte !== want.payload_byte)
        report("payload_byte", 32'(got.payload_byte), 32'(want.payload_byte));
      if (got.payload_index !== want.payload_index)
        report("payload_index", 32'(got.payload_index), 32'(want.payload_index));
      if (got.frame_type_out !== want.frame_type_out)
        report("frame_type_out", 32'(got.frame_type_out), 32'(want.frame_type_out));
      if (got.frame_length_out !== want.frame_length_out)
        report("frame_length_out", 32'(got.frame_length_out),
               32'(want.frame_length_out));
      if (got.check_byte_out !== want.check_byte_out)
        report("check_byte_out", 32'(got.check_byte_out), 32'(want.check_byte_out));
      if (got.frame_ok !== want.frame_ok)
        report("frame_ok", 32'(got.frame_ok), 32'(want.frame_ok));
    endtask
  endclass

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  sfd_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  sfd_out_t out_data;

  sfd_scoreboard sb = new();
  bit            quiet = 1'b0;  // full-rate stretch on both channels
  int            n_counted = 0;

  sniffer_frame_deframer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("sniffer_frame_deframer test failed");
    $finish;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_input(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  // receiver backpressure
  initial begin
    int n;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      n = pick_gap();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  task send_item(input sfd_in_t item);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  task send_byte(input logic [7:0] b);
    sfd_in_t item;
    item.func      = 1'b0;
    item.data_byte = b;
    send_item(item);
  endtask

  task send_recover(input logic [7:0] b);
    sfd_in_t item;
    item.func      = 1'b1;
    item.data_byte = b;
    send_item(item);
  endtask

  // hold the input idle until every outstanding result has come back
  task drain_pause();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task send_frames(input logic [7:0] bytes[$]);
    foreach (bytes[i]) send_byte(bytes[i]);
  endtask

  // One random frame: mostly well formed, some corrupted, truncated or noise.
  task random_frame();
    logic [7:0]  ftype;
    logic [15:0] raw;
    logic [7:0]  q[$];
    int          n;
    int          mode;
    int          pos;
    ftype = ($urandom_range(0, 3) == 0) ? SFD_TYPE_ADJ : 8'($urandom);
    n     = $urandom_range(0, 10);
    raw   = (ftype == SFD_TYPE_ADJ) ? 16'(n + 1) : 16'(n);
    mode  = $urandom_range(0, 99);
    if (mode < 70) begin
      q = {SFD_SOF1, SFD_SOF2, ftype, raw[7:0], raw[15:8]};
      repeat (n) q.push_back(8'($urandom));
      q.push_back(8'($urandom_range(1, 255)));
      q.push_back(SFD_EOF1);
      q.push_back(SFD_EOF2);
      send_frames(q);
      n_counted += q.size();
      if ($urandom_range(0, 9) == 0) begin
        send_recover(8'($urandom));
        n_counted++;
      end
    end else if (mode < 85) begin
      q = {SFD_SOF1, SFD_SOF2, ftype, raw[7:0], raw[15:8]};
      repeat (n) q.push_back(8'($urandom));
      q.push_back(8'($urandom_range(0, 1) ? 8'($urandom) : SFD_CHK_BAD));
      q.push_back(SFD_EOF1);
      q.push_back(SFD_EOF2);
      pos = $urandom_range(0, q.size() - 1);
      q[pos] = 8'($urandom);
      send_frames(q);
      send_recover(8'($urandom));
      n_counted += q.size() + 1;
    end else if (mode < 93) begin
      // long length, aborted partway through the payload
      q = {SFD_SOF1, SFD_SOF2, ftype, 8'($urandom), 8'($urandom_range(1, 255))};
      repeat ($urandom_range(1, 6)) q.push_back(8'($urandom));
      send_frames(q);
      send_recover(8'($urandom));
      n_counted += q.size() + 1;
    end else begin
      q = {};
      repeat ($urandom_range(1, 6)) q.push_back(8'($urandom));
      send_frames(q);
      send_recover(8'($urandom));
      n_counted += q.size() + 1;
    end
  endtask

  initial begin
    int  guard;
    bit  paused;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed
    send_recover(8'hFF);
    // zero length skips the payload
    send_frames({SFD_SOF1, SFD_SOF2, 8'h05, 8'h00, 8'h00, 8'h7F, SFD_EOF1, SFD_EOF2});
    // byte after success starts the next frame; adjusted length of zero
    send_frames({SFD_SOF1, SFD_SOF2, SFD_TYPE_ADJ, 8'h01, 8'h00, 8'hFF, SFD_EOF1,
                 SFD_EOF2});
    // bad start after success, then a data byte in the error phase
    send_byte(8'h00);
    send_byte(SFD_SOF1);
    send_recover(8'h00);
    // adjusted length wraps to all ones
    send_frames({SFD_SOF1, SFD_SOF2, SFD_TYPE_ADJ, 8'h00, 8'h00, 8'hFF});
    send_recover(8'h5A);
    drain_pause();

    // random
    paused = 1'b0;
    while (n_counted < 500) begin
      quiet = ($urandom_range(0, 4) == 0);
      random_frame();
      if (!paused && n_counted >= 250) begin
        drain_pause();
        paused = 1'b1;
      end
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    guard = 0;
    while (sb.pending() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    if (sb.pending() != 0) sb.report("results missing at end", 32'(sb.pending()), 32'd0);
    repeat (20) @(posedge clk);

    if (sb.errors == 0) begin
      $display("sniffer_frame_deframer test passed");
    end else begin
      $display("sniffer_frame_deframer test failed");
    end
    $finish;
  end

endmodule
